### design/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants for the cursor sequence buffer: sizes, request
// and error codes, and the command broadcast along the chain of entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

package csb_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_ADVANCE = 3'd1,
        REQ_INSERT  = 3'd2,
        REQ_ATTACH  = 3'd3,
        REQ_REMOVE  = 3'd4,
        REQ_QUERY   = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_NOCUR = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        CMD_HOLD  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [CNT_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] cursor;
        logic [CNT_W-1:0] count;
        t_err             err;
    } t_ctrl_stat;

endpackage

`default_nettype wire

### design/csb_cell.sv
// ----------------------------------------------------------------------------
// csb_cell
// One entry of the list. Each cycle it holds, takes its left neighbour when a
// gap opens, takes its right neighbour when the list closes, or loads the new
// value at the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_cell
    import csb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [CNT_W-1:0]      i_index,
    input  wire t_cell_cmd             i_cmd,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    output logic      [DATA_WIDTH-1:0] o_value
);

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            CMD_OPEN: begin
                if (i_index > i_cmd.pos) begin
                    n_value = i_left;
                end else if (i_index == i_cmd.pos) begin
                    n_value = i_cmd.value;
                end
            end
            CMD_CLOSE: begin
                if (i_index >= i_cmd.pos) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

### design/csb_ctrl.sv
// ----------------------------------------------------------------------------
// csb_ctrl
// Cursor and count bookkeeping. Decodes each accepted request, checks it,
// updates cursor and count and drives the command along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_ctrl
    import csb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [2:0]            i_req_type,
    input  wire logic [DATA_WIDTH-1:0] i_entry_value,
    output t_cell_cmd                  o_cmd,
    output t_ctrl_stat                 o_stat
);

    logic [CNT_W-1:0] r_cursor;
    logic [CNT_W-1:0] r_count;
    t_err             r_err;
    logic [CNT_W-1:0] n_cursor;
    logic [CNT_W-1:0] n_count;
    t_err             n_err;
    logic             w_cur;
    logic             w_full;

    assign w_cur  = r_cursor < r_count;
    assign w_full = r_count >= CNT_W'(DEPTH);

    always_comb begin
        n_cursor    = r_cursor;
        n_count     = r_count;
        n_err       = ERR_OK;
        o_cmd.op    = CMD_HOLD;
        o_cmd.pos   = r_cursor;
        o_cmd.value = i_entry_value;
        case (t_req'(i_req_type))
            REQ_START: n_cursor = '0;
            REQ_ADVANCE: begin
                if (!w_cur) begin
                    n_err = ERR_NOCUR;
                end else begin
                    n_cursor = r_cursor + CNT_W'(1);
                end
            end
            REQ_INSERT: begin
                if (w_full) begin
                    n_err = ERR_FULL;
                end else begin
                    o_cmd.op  = CMD_OPEN;
                    o_cmd.pos = w_cur ? r_cursor : '0;
                    n_cursor  = o_cmd.pos;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            REQ_ATTACH: begin
                if (w_full) begin
                    n_err = ERR_FULL;
                end else begin
                    o_cmd.op  = CMD_OPEN;
                    o_cmd.pos = w_cur ? r_cursor + CNT_W'(1) : r_count;
                    n_cursor  = o_cmd.pos;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            REQ_REMOVE: begin
                if (!w_cur) begin
                    n_err = ERR_NOCUR;
                end else begin
                    o_cmd.op = CMD_CLOSE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: n_cursor = r_cursor;
        endcase
        if (!i_accept) begin
            o_cmd.op = CMD_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_count  <= '0;
            r_err    <= ERR_OK;
        end else if (i_accept) begin
            r_cursor <= n_cursor;
            r_count  <= n_count;
            r_err    <= n_err;
        end
    end

    assign o_stat.cursor = r_cursor;
    assign o_stat.count  = r_count;
    assign o_stat.err    = r_err;

endmodule

`default_nettype wire

### design/cursor_sequence_buffer_unit.sv
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_unit
// Ordered list with a cursor, kept in a chain of entry cells that shift in
// parallel. One item updates the whole chain in the cycle it is accepted;
// the result is then registered in the show state once the output register
// is free or being taken, and no new item is accepted until that happens.
// Synchronous active-low reset empties the list and parks the cursor at 0;
// entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_sequence_buffer_unit
    import csb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [2:0]            i_req_type,
    input  wire logic [DATA_WIDTH-1:0] i_entry_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DATA_WIDTH-1:0]      o_current_value,
    output logic                       o_has_current,
    output logic [CNT_W-1:0]           o_item_count,
    output logic [1:0]                 o_error_code
);

    typedef enum logic {
        S_TAKE,
        S_SHOW
    } t_state;

    t_state                r_state;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_value;
    logic                  r_has;
    logic [CNT_W-1:0]      r_count;
    t_err                  r_err;

    logic                  w_accept;
    t_cell_cmd             w_cmd;
    t_ctrl_stat            w_stat;
    logic [DATA_WIDTH-1:0] w_cell [DEPTH];
    logic [DATA_WIDTH-1:0] w_left [DEPTH];
    logic [DATA_WIDTH-1:0] w_right [DEPTH];
    logic                  w_has;
    logic                  w_load;

    assign o_ready  = (r_state == S_TAKE);
    assign w_accept = i_valid && o_ready;

    csb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_req_type    (i_req_type),
        .i_entry_value (i_entry_value),
        .o_cmd         (w_cmd),
        .o_stat        (w_stat)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_rest
            assign w_left[g] = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_inner
            assign w_right[g] = w_cell[g+1];
        end

        csb_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CNT_W'(g)),
            .i_cmd   (w_cmd),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_value (w_cell[g])
        );
    end

    assign w_has  = w_stat.cursor < w_stat.count;
    assign w_load = (r_state == S_SHOW) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_TAKE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_TAKE: begin
                    if (w_accept) begin
                        r_state <= S_SHOW;
                    end
                    if (r_out_valid && i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_SHOW: begin
                    if (w_load) begin
                        r_state     <= S_TAKE;
                        r_out_valid <= 1'b1;
                        r_value     <= w_has ? w_cell[w_stat.cursor[IDX_W-1:0]] : '0;
                        r_has       <= w_has;
                        r_count     <= w_stat.count;
                        r_err       <= w_stat.err;
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_current_value = r_value;
    assign o_has_current   = r_has;
    assign o_item_count    = r_count;
    assign o_error_code    = r_err;

endmodule

`default_nettype wire

### tb/sv/cursor_sequence_buffer_unit_test.sv
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_unit_test
// Self-checking testbench for the cursor sequence buffer. Request items are
// sent through the valid/ready input channel, and a shadow list predicts
// the result of every accepted item. Each result taken from the output channel
// is compared field by field, in order. Directed cases on an empty and a full
// list come first. Random traffic follows, phase by phase, under different
// amounts of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import csb_pkg::*;

    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [DATA_WIDTH-1:0] current_value;
        logic                  has_current;
        logic [CNT_W-1:0]      item_count;
        t_err                  error_code;
    } t_list_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [2:0]            i_req_type;
    logic [DATA_WIDTH-1:0] i_entry_value;
    logic                  o_valid;
    logic                  i_ready;
    logic [DATA_WIDTH-1:0] o_current_value;
    logic                  o_has_current;
    logic [CNT_W-1:0]      o_item_count;
    logic [1:0]            o_error_code;

    logic [DATA_WIDTH-1:0] list_entries [DEPTH];
    int                    list_count  = 0;
    int                    list_cursor = 0;
    t_list_result          predicted_results [$];
    int                    mismatch_count     = 0;
    int                    sender_idle_pct    = 0;
    int                    receiver_stall_pct = 0;

    cursor_sequence_buffer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_entry_value   (i_entry_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_current_value (o_current_value),
        .o_has_current   (o_has_current),
        .o_item_count    (o_item_count),
        .o_error_code    (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_list_result step_list(logic [2:0] req, logic [DATA_WIDTH-1:0] value);
        t_list_result res;
        t_err         err;
        logic         has_cur;
        int           i;
        err     = ERR_OK;
        has_cur = (list_cursor < list_count);
        case (req)
            REQ_START: begin
                list_cursor = 0;
            end
            REQ_ADVANCE: begin
                if (!has_cur) err = ERR_NOCUR;
                else list_cursor++;
            end
            REQ_INSERT: begin
                if (list_count >= DEPTH) begin
                    err = ERR_FULL;
                end else begin
                    if (!has_cur) list_cursor = 0;
                    for (i = list_count; i > list_cursor; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[list_cursor] = value;
                    list_count++;
                end
            end
            REQ_ATTACH: begin
                if (list_count >= DEPTH) begin
                    err = ERR_FULL;
                end else begin
                    if (has_cur) begin
                        list_cursor++;
                        for (i = list_count; i > list_cursor; i--)
                            list_entries[i] = list_entries[i-1];
                    end else begin
                        list_cursor = list_count;
                    end
                    list_entries[list_cursor] = value;
                    list_count++;
                end
            end
            REQ_REMOVE: begin
                if (!has_cur) begin
                    err = ERR_NOCUR;
                end else begin
                    for (i = list_cursor; i + 1 < list_count; i++)
                        list_entries[i] = list_entries[i+1];
                    list_count--;
                end
            end
            default: begin
            end
        endcase
        res.has_current   = (list_cursor < list_count);
        res.current_value = res.has_current ? list_entries[list_cursor] : '0;
        res.item_count    = list_count[CNT_W-1:0];
        res.error_code    = err;
        return res;
    endfunction

    // results are checked before the item accepted at the same edge is predicted
    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (predicted_results.size() == 0) begin
                $error("result with no item outstanding");
                mismatch_count++;
            end else begin
                exp_res = predicted_results.pop_front();
                if (o_current_value !== exp_res.current_value) begin
                    $error("current_value expected %h actual %h",
                           exp_res.current_value, o_current_value);
                    mismatch_count++;
                end
                if (o_has_current !== exp_res.has_current) begin
                    $error("has_current expected %0d actual %0d",
                           exp_res.has_current, o_has_current);
                    mismatch_count++;
                end
                if (o_item_count !== exp_res.item_count) begin
                    $error("item_count expected %0d actual %0d",
                           exp_res.item_count, o_item_count);
                    mismatch_count++;
                end
                if (o_error_code !== exp_res.error_code) begin
                    $error("error_code expected %0d actual %0d",
                           exp_res.error_code, o_error_code);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && i_valid && o_ready)
            predicted_results.push_back(step_list(i_req_type, i_entry_value));
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return DATA_WIDTH'($urandom);
    endfunction

    task automatic send_request(logic [2:0] req, logic [DATA_WIDTH-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_entry_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic run_random_traffic(int n_items);
        logic        growing;
        int          run_left;
        int          r;
        logic [2:0]  req;
        growing  = 1'b1;
        run_left = $urandom_range(60, 20);
        for (int n = 0; n < n_items; n++) begin
            if (run_left == 0) begin
                growing  = ~growing;
                run_left = $urandom_range(60, 20);
            end
            run_left--;
            r = $urandom_range(99);
            if (r < 8)                         req = REQ_START;
            else if (r < (growing ? 20 : 22))  req = REQ_ADVANCE;
            else if (r < (growing ? 45 : 32))  req = REQ_INSERT;
            else if (r < (growing ? 70 : 42))  req = REQ_ATTACH;
            else if (r < 80)                   req = REQ_REMOVE;
            else if (r < 88)                   req = REQ_QUERY;
            else if (r < 94)                   req = REQ_RSVD6;
            else                               req = REQ_RSVD7;
            send_request(req, pick_value());
        end
    endtask

    task automatic test_directed_edges();
        sender_idle_pct    = 20;
        receiver_stall_pct = 20;
        send_request(REQ_QUERY,   32'h0000_0000);
        send_request(REQ_ADVANCE, 32'hFFFF_FFFF);
        send_request(REQ_REMOVE,  32'h1234_5678);
        send_request(REQ_START,   32'h0000_0000);
        send_request(REQ_INSERT,  32'h0000_0000);
        send_request(REQ_INSERT,  32'hFFFF_FFFF);
        send_request(REQ_ATTACH,  32'h1234_5678);
        send_request(REQ_START,   32'hDEAD_BEEF);
        send_request(REQ_ADVANCE, 32'h0000_0000);
        send_request(REQ_ADVANCE, 32'h0000_0000);
        send_request(REQ_ADVANCE, 32'h0000_0000);
        send_request(REQ_ATTACH,  32'hA5A5_A5A5);
        send_request(REQ_ADVANCE, 32'h0000_0000);
        send_request(REQ_INSERT,  32'h5A5A_5A5A);
        send_request(REQ_REMOVE,  32'h0000_0000);
        send_request(REQ_RSVD6,   32'hFFFF_FFFF);
        send_request(REQ_RSVD7,   32'h8000_0001);
        send_request(REQ_ADVANCE, 32'h0000_0000);
        send_request(REQ_REMOVE,  32'h0000_0000);
        send_request(REQ_QUERY,   32'hFFFF_FFFF);
        send_request(REQ_ATTACH,  32'h8000_0000);
        send_request(REQ_INSERT,  32'h0000_0001);
    endtask

    // enough attaches and removes to reach full and empty from any count
    task automatic test_full_list();
        sender_idle_pct    = 20;
        receiver_stall_pct = 20;
        for (int n = 0; n < DEPTH + 4; n++) send_request(REQ_ATTACH, pick_value());
        send_request(REQ_INSERT, pick_value());
        send_request(REQ_START,  pick_value());
        send_request(REQ_INSERT, pick_value());
        for (int n = 0; n < DEPTH + 1; n++) send_request(REQ_ADVANCE, pick_value());
        send_request(REQ_ATTACH, pick_value());
        send_request(REQ_START,  pick_value());
        for (int n = 0; n < DEPTH + 2; n++) send_request(REQ_REMOVE, pick_value());
        send_request(REQ_QUERY,  pick_value());
    endtask

    task automatic test_random_no_idle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random_traffic(300);
    endtask

    task automatic test_random_sender_idle();
        sender_idle_pct    = 88;
        receiver_stall_pct = 0;
        run_random_traffic(300);
    endtask

    task automatic test_random_receiver_stall();
        sender_idle_pct    = 0;
        receiver_stall_pct = 88;
        run_random_traffic(300);
    endtask

    task automatic test_random_both_idle();
        sender_idle_pct    = 20;
        receiver_stall_pct = 20;
        run_random_traffic(300);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req_type    = REQ_QUERY;
        i_entry_value = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_full_list();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        @(negedge i_clk);
        i_valid            <= 1'b0;
        receiver_stall_pct = 0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
design/csb_pkg.sv
design/csb_cell.sv
design/csb_ctrl.sv
design/cursor_sequence_buffer_unit.sv
tb/sv/cursor_sequence_buffer_unit_test.sv
